// File: sv/assert_macros.svh
// Assertion helpers shared by the frame manager modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while the synchronous reset is held low.
`define CBFM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked property that is checked on every edge, reset included.
`define CBFM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: sv/cbfm_pkg.sv
package cbfm_pkg;

  localparam int FRAMES_DEF = 16;
  localparam int FRAME_W    = 4;
  localparam int PIN_W      = 8;
  localparam logic [PIN_W-1:0] PIN_MAX = 8'hFF;

  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_UNPIN   = 2'd1;
  localparam logic [1:0] OP_DISPOSE = 2'd2;

  typedef enum logic [2:0] {
    ST_DONE,
    ST_LOADED,
    ST_NOFREE,
    ST_NOTPINNED,
    ST_NOTFOUND
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] file_id;
    logic [31:0] page_no;
    logic        dirty;
  } in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    status_t            status;
    logic               evict_valid;
    logic               evict_dirty;
    logic [15:0]        evict_file;
    logic [31:0]        evict_page;
  } out_t;

  // One frame descriptor as held in the frame table.
  typedef struct packed {
    logic [15:0]      file;
    logic [31:0]      page;
    logic [PIN_W-1:0] pins;
    logic             refb;
    logic             dirty;
  } slot_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SWEEP,
    S_DONE
  } state_t;

endpackage

// File: sv/cbfm_ram.sv
module cbfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/cbfm_ctrl.sv
`include "assert_macros.svh"

module cbfm_ctrl #(
  parameter int FRAMES = cbfm_pkg::FRAMES_DEF,
  localparam int IDX_W = $clog2(FRAMES)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  cbfm_pkg::in_t  req,
  output logic           idle,
  output cbfm_pkg::out_t res,
  output logic           res_valid,
  input  logic           res_ready
);

  import cbfm_pkg::*;

  localparam int SW_W = $clog2(2 * FRAMES + 1);
  localparam logic [SW_W-1:0]  SW_LIMIT = SW_W'(2 * FRAMES);
  localparam logic [IDX_W-1:0] LAST     = IDX_W'(FRAMES - 1);

  state_t            state_r, state_nxt;
  in_t               req_r, req_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  hand_r, hand_nxt;
  logic [SW_W-1:0]   cnt_r, cnt_nxt;
  logic [FRAMES-1:0] valid_r, valid_nxt;
  out_t              res_r, res_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  slot_t            wdata;
  slot_t            rdata;
  slot_t            upd;
  logic             hit;
  logic             sw_load;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x);
    return (x == LAST) ? '0 : x + 1'b1;
  endfunction

  cbfm_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    idx_nxt   = idx_r;
    hand_nxt  = hand_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    res_nxt   = res_r;
    we        = 1'b0;
    waddr     = idx_r;
    wdata     = rdata;
    raddr     = '0;
    sw_load   = 1'b0;
    upd       = rdata;
    hit       = valid_r[idx_r] && (rdata.file == req_r.file_id) &&
                (rdata.page == req_r.page_no);

    unique case (state_r)
      S_IDLE: begin
        // Frame zero is always being read here, so the scan starts at once.
        if (start) begin
          req_nxt = req;
          idx_nxt = '0;
          res_nxt = '0;
          if (req.op == OP_READ || req.op == OP_UNPIN || req.op == OP_DISPOSE) begin
            state_nxt = S_LOOK;
          end else begin
            res_nxt.status = ST_NOTFOUND;
            state_nxt      = S_DONE;
          end
        end
      end

      S_LOOK: begin
        raddr = wrap_inc(idx_r);
        if (hit) begin
          res_nxt.frame  = FRAME_W'(idx_r);
          res_nxt.status = ST_DONE;
          state_nxt      = S_DONE;
          case (req_r.op)
            OP_READ: begin
              upd.pins = (rdata.pins == PIN_MAX) ? rdata.pins : rdata.pins + 1'b1;
              upd.refb = 1'b1;
              we       = 1'b1;
              wdata    = upd;
            end
            OP_UNPIN: begin
              if (rdata.pins == '0) begin
                res_nxt.status = ST_NOTPINNED;
              end else begin
                upd.pins  = rdata.pins - 1'b1;
                upd.dirty = rdata.dirty | req_r.dirty;
                we        = 1'b1;
                wdata     = upd;
              end
            end
            OP_DISPOSE: begin
              valid_nxt[idx_r] = 1'b0;
            end
            default: ;
          endcase
        end else if (idx_r == LAST) begin
          if (req_r.op == OP_READ) begin
            raddr     = hand_r;
            cnt_nxt   = '0;
            state_nxt = S_SWEEP;
          end else begin
            res_nxt.status = ST_NOTFOUND;
            state_nxt      = S_DONE;
          end
        end else begin
          idx_nxt = wrap_inc(idx_r);
        end
      end

      S_SWEEP: begin
        // The next frame is read ahead while the one under the hand is judged.
        raddr = wrap_inc(hand_r);
        waddr = hand_r;
        if (cnt_r == SW_LIMIT) begin
          res_nxt.status = ST_NOFREE;
          state_nxt      = S_DONE;
        end else if (!valid_r[hand_r]) begin
          sw_load = 1'b1;
        end else if (rdata.pins != '0) begin
          cnt_nxt  = cnt_r + 1'b1;
          hand_nxt = wrap_inc(hand_r);
        end else if (rdata.refb) begin
          upd.refb = 1'b0;
          we       = 1'b1;
          wdata    = upd;
          cnt_nxt  = cnt_r + 1'b1;
          hand_nxt = wrap_inc(hand_r);
        end else begin
          sw_load             = 1'b1;
          res_nxt.evict_valid = 1'b1;
          res_nxt.evict_dirty = rdata.dirty;
          res_nxt.evict_file  = rdata.file;
          res_nxt.evict_page  = rdata.page;
        end
        if (sw_load) begin
          we                = 1'b1;
          wdata.file        = req_r.file_id;
          wdata.page        = req_r.page_no;
          wdata.pins        = PIN_W'(1);
          wdata.refb        = 1'b1;
          wdata.dirty       = 1'b0;
          valid_nxt[hand_r] = 1'b1;
          res_nxt.frame     = FRAME_W'(hand_r);
          res_nxt.status    = ST_LOADED;
          state_nxt         = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hand_r  <= LAST;
      cnt_r   <= '0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      hand_r  <= hand_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res       = res_r;
  assign res_valid = (state_r == S_DONE);

  `CBFM_ASSERT(a_no_rw_clash, clk, rst_n, we |-> (waddr != raddr), "table read and write clash")
  `CBFM_ASSERT(a_sweep_bound, clk, rst_n, cnt_r <= SW_LIMIT, "sweep count overran")
  `CBFM_ASSERT(a_load_valid, clk, rst_n, sw_load |=> valid_r[$past(hand_r)], "lost valid bit")

endmodule

// File: sv/clock_buffer_frame_manager.sv
// Buffer-frame manager with clock (second-chance) replacement. Each request word
// (read and pin, unpin, or dispose of a file page) yields exactly one result word.
// A request is taken only while the manager is idle; the frame descriptors live in
// a single-port-read table, so the lookup visits one frame per cycle in frame order
// and stops at the first match, examining up to FRAMES frames. A read that misses
// then runs the clock hand, again one frame per cycle through the same read port,
// and gives up with no free frame once the hand has advanced 2*FRAMES times. The
// finished result sits in an output register, so a new request may be accepted
// while the previous result still waits to be taken.
`include "assert_macros.svh"

module clock_buffer_frame_manager #(
  parameter int FRAMES = cbfm_pkg::FRAMES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cbfm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cbfm_pkg::out_t out_data
);

  import cbfm_pkg::*;

  logic idle;
  logic res_valid;
  logic res_ready;
  out_t res;

  out_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  // The sequencer owns the frame table, the valid bits and the clock hand.
  cbfm_ctrl #(
    .FRAMES (FRAMES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && in_ready),
    .req       (in_data),
    .idle      (idle),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  assign in_ready  = idle;
  // The output register can take a new result when it is empty or being emptied.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `CBFM_ASSERT(a_out_from_res, clk, rst_n, $rose(out_valid_r) |-> $past(res_valid), "result word appeared without a finished request")

endmodule

// File: sim/tb_clock_buffer_frame_manager.sv
`timescale 1ns / 1ps

module tb_clock_buffer_frame_manager;
  import cbfm_pkg::*;

  localparam int FRAMES = FRAMES_DEF;
  // Operation code three is not defined by the block and must come back as not found.
  localparam logic [1:0] OP_RESERVED = 2'd3;
  // Receiver hold-off used by the back-pressure test, counted in clock cycles.
  localparam int HOLD_CYCLES = 300;
  // Margin after the last awaited result before the verdict is given.
  localparam int TAIL_CYCLES = 60;
  // Longest stretch without any accepted word before the run is abandoned.
  localparam int QUIET_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  clock_buffer_frame_manager #(.FRAMES(FRAMES)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our own copy of the frame table and the clock hand. It is advanced once for every
  // request word at the moment that word is accepted, so the results that it yields
  // line up with the order in which the block must answer.
  logic             fr_valid [FRAMES];
  logic [PIN_W-1:0] fr_pins  [FRAMES];
  logic             fr_ref   [FRAMES];
  logic             fr_dirty [FRAMES];
  logic [15:0]      fr_file  [FRAMES];
  logic [31:0]      fr_page  [FRAMES];
  int               clock_hand;

  // Result words that have been worked out but not yet delivered, oldest first.
  out_t awaited_results[$];

  // Small pool of file ids and page numbers, so that random requests hit resident
  // pages often, and pages that share a file id or a page number sit side by side.
  logic [15:0] key_files [4];
  logic [31:0] key_pages [6];

  int  mismatches;
  bit  gaps_on;
  bit  stalls_on;
  int  holds_asked;

  // Works out the result of one request word and moves the frame table on.
  function automatic out_t model_frame_request(in_t w);
    out_t r;
    int   hit;
    int   n;
    bit   got;
    r   = '0;
    hit = FRAMES;
    // The lowest-numbered valid frame that holds the page wins.
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (fr_valid[i] && fr_file[i] == w.file_id && fr_page[i] == w.page_no) begin
        hit = i;
      end
    end
    case (w.op)
      OP_READ: begin
        if (hit < FRAMES) begin
          // A hit pins the page once more, up to the ceiling, and marks it referenced.
          if (fr_pins[hit] != PIN_MAX) begin
            fr_pins[hit] = fr_pins[hit] + 1'b1;
          end
          fr_ref[hit] = 1'b1;
          r.frame     = hit[FRAME_W-1:0];
          r.status    = ST_DONE;
        end else begin
          // Second-chance sweep: pinned frames are passed over, referenced ones lose
          // their reference bit, and the first free or unreferenced frame is taken.
          n   = 0;
          got = 1'b0;
          while (n < 2 * FRAMES && !got) begin
            if (!fr_valid[clock_hand]) begin
              got = 1'b1;
            end else if (fr_pins[clock_hand] != '0) begin
              n++;
              clock_hand = (clock_hand + 1 >= FRAMES) ? 0 : clock_hand + 1;
            end else if (fr_ref[clock_hand]) begin
              fr_ref[clock_hand] = 1'b0;
              n++;
              clock_hand = (clock_hand + 1 >= FRAMES) ? 0 : clock_hand + 1;
            end else begin
              r.evict_valid = 1'b1;
              r.evict_dirty = fr_dirty[clock_hand];
              r.evict_file  = fr_file[clock_hand];
              r.evict_page  = fr_page[clock_hand];
              got           = 1'b1;
            end
          end
          if (!got) begin
            r.status = ST_NOFREE;
          end else begin
            fr_valid[clock_hand] = 1'b1;
            fr_pins[clock_hand]  = PIN_W'(1);
            fr_ref[clock_hand]   = 1'b1;
            fr_dirty[clock_hand] = 1'b0;
            fr_file[clock_hand]  = w.file_id;
            fr_page[clock_hand]  = w.page_no;
            r.frame              = clock_hand[FRAME_W-1:0];
            r.status             = ST_LOADED;
          end
        end
      end
      OP_UNPIN: begin
        if (hit == FRAMES) begin
          r.status = ST_NOTFOUND;
        end else if (fr_pins[hit] == '0) begin
          r.frame  = hit[FRAME_W-1:0];
          r.status = ST_NOTPINNED;
        end else begin
          fr_pins[hit] = fr_pins[hit] - 1'b1;
          if (w.dirty) begin
            fr_dirty[hit] = 1'b1;
          end
          r.frame  = hit[FRAME_W-1:0];
          r.status = ST_DONE;
        end
      end
      OP_DISPOSE: begin
        if (hit == FRAMES) begin
          r.status = ST_NOTFOUND;
        end else begin
          // The frame is released even while it is still pinned.
          fr_valid[hit] = 1'b0;
          fr_pins[hit]  = '0;
          fr_ref[hit]   = 1'b0;
          fr_dirty[hit] = 1'b0;
          r.frame       = hit[FRAME_W-1:0];
          r.status      = ST_DONE;
        end
      end
      default: begin
        r.status = ST_NOTFOUND;
      end
    endcase
    return r;
  endfunction

  // Random request word: mostly pages from the pool, now and then any page at all.
  function automatic in_t random_request();
    in_t w;
    int  pick;
    pick    = $urandom_range(0, 99);
    w.op    = (pick < 38) ? OP_READ : (pick < 82) ? OP_UNPIN :
              (pick < 96) ? OP_DISPOSE : OP_RESERVED;
    w.dirty = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 19) == 0) begin
      w.file_id = 16'($urandom);
      w.page_no = $urandom;
    end else begin
      w.file_id = key_files[$urandom_range(0, 3)];
      w.page_no = key_pages[$urandom_range(0, 5)];
    end
    return w;
  endfunction

  // Offers one request word from a falling edge and holds it until it is taken. Once
  // accepted, its result is predicted and queued; a short gap may follow.
  task automatic send_request(input logic [1:0] op, input logic [15:0] file_id,
                              input logic [31:0] page_no, input logic dirty);
    in_t w;
    w.op      = op;
    w.file_id = file_id;
    w.page_no = page_no;
    w.dirty   = dirty;
    in_valid <= 1'b1;
    in_data  <= w;
    do begin
      @(posedge clk);
    end while (!in_ready);
    awaited_results.push_back(model_frame_request(w));
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic send_random(input int count);
    in_t w;
    repeat (count) begin
      w = random_request();
      send_request(w.op, w.file_id, w.page_no, w.dirty);
    end
  endtask

  // Every operation once, the extreme keys, the reserved code, the dirty flag on
  // operations that must ignore it, an unpin past zero and a dispose of a pinned page.
  task automatic test_basic_ops();
    send_request(OP_READ,     16'h0000, 32'h0000_0000, 1'b1);
    send_request(OP_READ,     16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_READ,     16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_UNPIN,    16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(OP_UNPIN,    16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_UNPIN,    16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_UNPIN,    16'h1234, 32'h0000_0005, 1'b1);
    send_request(OP_DISPOSE,  16'h8000, 32'h8000_0000, 1'b0);
    send_request(OP_RESERVED, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(OP_DISPOSE,  16'h0000, 32'h0000_0000, 1'b1);
    send_request(OP_DISPOSE,  16'h0000, 32'h0000_0000, 1'b0);
  endtask

  // Fifteen new pages fill the free frames, the first of them giving the unpinned dirty
  // page its second chance on the way; the sixteenth evicts that page with write-back;
  // the seventeenth finds every frame pinned.
  task automatic test_full_pool();
    for (int i = 0; i < FRAMES + 1; i++) begin
      send_request(OP_READ, 16'h5A00 | 16'(i), 32'hA5A5_0000 + 32'(i), 1'b0);
    end
  endtask

  // Enough hits on one page to run its pin count into the ceiling, then one unpin.
  task automatic test_pin_ceiling();
    repeat (258) send_request(OP_READ, 16'h5A00, 32'hA5A5_0000, 1'b0);
    send_request(OP_UNPIN, 16'h5A00, 32'hA5A5_0000, 1'b1);
  endtask

  // Disposes every resident page so that the random traffic starts from a free pool.
  task automatic test_release_all();
    for (int i = 0; i < FRAMES; i++) begin
      if (fr_valid[i]) begin
        send_request(OP_DISPOSE, fr_file[i], fr_page[i], 1'b0);
      end
    end
  endtask

  task automatic test_random_traffic(input int count);
    send_random(count);
  endtask

  // The receiver stops taking results for a long while; the sender keeps offering,
  // so the block fills up and must hold its input off.
  task automatic test_backpressure();
    holds_asked++;
    send_random(40);
  endtask

  // The sender stops until every outstanding result has been delivered, then resumes.
  task automatic test_drain_pause();
    send_random(40);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(negedge clk);
    send_random(40);
  endtask

  // Result side: out_ready changes on the falling edge. It is dropped in short random
  // bursts while stalls are enabled, and for a long stretch whenever one is asked for.
  initial begin : result_receiver
    int stall_left;
    int hold_left;
    int holds_served;
    stall_left   = 0;
    hold_left    = 0;
    holds_served = 0;
    out_ready    = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every delivered result word is compared, field by field, with the oldest prediction.
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result word with no request outstanding: %h", out_data);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.frame !== want.frame) begin
          $error("frame: expected %0d, got %0d", want.frame, out_data.frame);
          mismatches++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.evict_valid !== want.evict_valid) begin
          $error("evict_valid: expected %0d, got %0d", want.evict_valid,
                 out_data.evict_valid);
          mismatches++;
        end
        if (out_data.evict_dirty !== want.evict_dirty) begin
          $error("evict_dirty: expected %0d, got %0d", want.evict_dirty,
                 out_data.evict_dirty);
          mismatches++;
        end
        if (out_data.evict_file !== want.evict_file) begin
          $error("evict_file: expected %h, got %h", want.evict_file, out_data.evict_file);
          mismatches++;
        end
        if (out_data.evict_page !== want.evict_page) begin
          $error("evict_page: expected %h, got %h", want.evict_page, out_data.evict_page);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: the run is abandoned if no word moves on either side for too long.
  always @(posedge clk) begin : quiet_watch
    int quiet;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end else begin
      quiet = 0;
    end
  end

  initial begin : stimulus
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    holds_asked = 0;
    mismatches  = 0;
    clock_hand  = FRAMES - 1;
    for (int i = 0; i < FRAMES; i++) begin
      fr_valid[i] = 1'b0;
      fr_pins[i]  = '0;
      fr_ref[i]   = 1'b0;
      fr_dirty[i] = 1'b0;
      fr_file[i]  = '0;
      fr_page[i]  = '0;
    end
    for (int i = 0; i < 4; i++) begin
      key_files[i] = 16'($urandom);
    end
    for (int i = 0; i < 6; i++) begin
      key_pages[i] = $urandom;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_full_pool();
    test_pin_ceiling();
    test_release_all();
    test_random_traffic(600);
    test_backpressure();
    test_drain_pause();

    // The closing stretch runs flat out on both sides.
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_random_traffic(450);
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/cbfm_pkg.sv
sv/cbfm_ram.sv
sv/cbfm_ctrl.sv
sv/clock_buffer_frame_manager.sv
sim/tb_clock_buffer_frame_manager.sv
